FILE: rtl/sha_pkg.sv
package sha_pkg;

  localparam int WordW = 32;
  localparam int HashWords = 8;
  localparam int BlockBytes = 64;
  localparam int Rounds = 64;
  localparam int MsgW = 61;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;
  localparam logic [2:0] MaxBytes = 3'd4;

  typedef logic [WordW-1:0] word_t;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } cmp_ctl_t;

endpackage

FILE: rtl/sha256_hash_engine.sv
// SHA-256 hash engine.
// Input channel (in_valid/in_ready): each transaction carries up to four
// message bytes from the top of in_data_word, in_byte_count of them
// (5 to 7 treated as 4), and in_end_of_message to close the message.
// Output channel (out_valid/out_ready): after a closing transaction the
// eight digest words leave in order, out_word_index 0 to 7, with
// out_last_word on the eighth.
// Flow: bytes enter the block buffer one per cycle, pausing while each full
// 64-byte block is compressed in the single round unit, one round per cycle.
// Closing adds padding bytes one per cycle with the same pauses, one or two
// compressions, then the digest.
// in_ready is low while bytes, padding, compressions or the digest run.
// Reset (synchronous, rst_n low) loads the initial hash values and clears
// the byte and length counters; the buffer needs no clearing.
// A stalled receiver holds the current digest word on out_ and freezes the
// engine; nothing is dropped.
module sha256_hash_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_data_word,
  input  logic [2:0]            in_byte_count,
  input  logic                  in_end_of_message,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_digest_word,
  output logic [2:0]            out_word_index,
  output logic                  out_last_word
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_BYTE = 3'd1;
  localparam logic [2:0] S_PAD  = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                 state_r;
  logic [31:0]                word_r;
  logic [2:0]                 cnt_r, idx_r;
  logic                       eom_r, padding_r;
  logic [3:0]                 pad_r;
  logic [5:0]                 fill_r;
  logic [sha_pkg::MsgW-1:0]   len_r;
  logic [63:0]                bits_r;
  sha_pkg::word_t [7:0]       hash_r;
  sha_pkg::word_t [7:0]       h_new;
  logic [sha_pkg::BlockBytes*8-1:0] blk_r;
  logic                       cmp_start;
  sha_pkg::cmp_ctl_t          ctl;
  logic [7:0]                 wr_byte;
  logic                       wr_en;

  sha_round u_round (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmp_start),
    .block (blk_r),
    .h_in  (hash_r),
    .h_out (h_new),
    .ctl   (ctl)
  );

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_digest_word = hash_r[idx_r];
  assign out_word_index = idx_r;
  assign out_last_word = (idx_r == 3'd7);
  assign cmp_start = (state_r == S_CMP) && !ctl.busy && !ctl.done;

  always_comb begin
    wr_en = 1'b0;
    wr_byte = 8'h00;
    if (state_r == S_BYTE && cnt_r != 3'd0) begin
      wr_en = 1'b1;
      wr_byte = word_r[31:24];
    end else if (state_r == S_PAD) begin
      wr_en = 1'b1;
      if (pad_r == 4'd0) begin
        wr_byte = sha_pkg::PadByte;
      end else if (pad_r == 4'd1) begin
        wr_byte = 8'h00;
      end else begin
        wr_byte = bits_r[63:56];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      blk_r <= {blk_r[sha_pkg::BlockBytes*8-9:0], wr_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      len_r     <= '0;
      idx_r     <= '0;
      padding_r <= 1'b0;
      pad_r     <= '0;
      cnt_r     <= '0;
      eom_r     <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        hash_r[i] <= sha_pkg::init_hash(3'(i));
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            word_r  <= in_data_word;
            cnt_r   <= (in_byte_count > sha_pkg::MaxBytes) ? sha_pkg::MaxBytes
                                                          : in_byte_count;
            eom_r   <= in_end_of_message;
            state_r <= S_BYTE;
          end
        end
        S_BYTE: begin
          if (cnt_r != 3'd0) begin
            word_r <= {word_r[23:0], 8'h00};
            cnt_r  <= cnt_r - 3'd1;
            fill_r <= fill_r + 6'd1;
            len_r  <= len_r + {{(sha_pkg::MsgW-1){1'b0}}, 1'b1};
            if (fill_r == 6'd63) begin
              state_r <= S_CMP;
            end
          end else if (eom_r) begin
            padding_r <= 1'b1;
            pad_r     <= 4'd0;
            bits_r    <= {len_r, 3'b000};
            state_r   <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_PAD: begin
          fill_r <= fill_r + 6'd1;
          if (pad_r >= 4'd2) begin
            bits_r <= {bits_r[55:0], 8'h00};
          end
          if (pad_r == 4'd0 || pad_r == 4'd1) begin
            pad_r <= (fill_r + 6'd1 == sha_pkg::LenPos) ? 4'd2 : 4'd1;
          end else begin
            pad_r <= pad_r + 4'd1;
          end
          if (fill_r == 6'd63) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (ctl.done) begin
            hash_r <= h_new;
            if (padding_r && pad_r == 4'd10) begin
              idx_r   <= '0;
              state_r <= S_OUT;
            end else if (padding_r) begin
              state_r <= S_PAD;
            end else begin
              state_r <= S_BYTE;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                hash_r[i] <= sha_pkg::init_hash(3'(i));
              end
              fill_r    <= '0;
              len_r     <= '0;
              padding_r <= 1'b0;
              state_r   <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sha_round.sv
module sha_round (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [sha_pkg::BlockBytes*8-1:0] block,
  input  sha_pkg::word_t [sha_pkg::HashWords-1:0] h_in,
  output sha_pkg::word_t [sha_pkg::HashWords-1:0] h_out,
  output sha_pkg::cmp_ctl_t               ctl
);

  logic                      busy_r, done_r;
  logic [5:0]                t_r;
  sha_pkg::word_t [15:0]     w_r;
  sha_pkg::word_t [7:0]      v_r;
  sha_pkg::word_t [7:0]      hs_r;
  sha_pkg::word_t            w_nxt, t1, t2, s0, s1, bs0, bs1, chs, mj;

  always_comb begin
    s0 = {w_r[1][6:0], w_r[1][31:7]} ^ {w_r[1][17:0], w_r[1][31:18]} ^ (w_r[1] >> 3);
    s1 = {w_r[14][16:0], w_r[14][31:17]} ^ {w_r[14][18:0], w_r[14][31:19]}
       ^ (w_r[14] >> 10);
    w_nxt = w_r[0] + s0 + w_r[9] + s1;
    bs1 = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
        ^ {v_r[4][24:0], v_r[4][31:25]};
    chs = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + bs1 + chs + sha_pkg::round_k(t_r) + w_r[0];
    bs0 = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
        ^ {v_r[0][21:0], v_r[0][31:22]};
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = bs0 + mj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      t_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        t_r    <= '0;
      end else if (busy_r) begin
        t_r <= t_r + 6'd1;
        if (t_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      for (int i = 0; i < 16; i++) begin
        w_r[i] <= block[(sha_pkg::BlockBytes*8-1)-32*i -: 32];
      end
      v_r  <= h_in;
      hs_r <= h_in;
    end else if (busy_r) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_nxt;
      v_r <= {v_r[6], v_r[5], v_r[4], v_r[3] + t1, v_r[2], v_r[1], v_r[0], t1 + t2};
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_out[i] = hs_r[i] + v_r[i];
    end
    ctl.start = start;
    ctl.busy  = busy_r;
    ctl.done  = done_r;
  end

endmodule

FILE: rtl/sha_checker.sv
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word mismatch");

  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest order broken");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken during digest");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_digest_word)))
    else $error("stalled result changed");

endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_digest_word (out_digest_word),
  .out_word_index  (out_word_index),
  .out_last_word   (out_last_word)
);
